// ----- rtl/tunnel_relay_client_table_unit_assert.svh -----
// Assertion macros for the tunnel relay client table unit
`ifndef TUNNEL_RELAY_CLIENT_TABLE_UNIT_ASSERT_SVH
`define TUNNEL_RELAY_CLIENT_TABLE_UNIT_ASSERT_SVH
// implication checked on every clock, quiet during reset
`define TRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/trct_pkg.sv -----
// Shared types and constants for the tunnel relay client table
`timescale 1ns / 1ps
package trct_pkg;
    localparam int CLIENTS_DEF = 32;
    localparam logic [15:0] HDR_BYTES = 16'd30;
    localparam logic [15:0] CSUM_OK = 16'hffff;
    localparam logic [47:0] NODE_BCAST = 48'hffffffffffff;
    localparam logic [31:0] AGE_RESET = 32'd900;

    localparam logic [2:0] ST_ACK = 3'd0;
    localparam logic [2:0] ST_FWD = 3'd1;
    localparam logic [2:0] ST_BAD = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_NOTARGET = 3'd4;
    localparam logic [2:0] ST_REFUSED = 3'd5;
    localparam logic [2:0] ST_TICK = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_AGE1, S_AGE1_CHK, S_CLASSIFY, S_FREE, S_REG,
        S_FIND, S_FIND_CHK, S_MOVE, S_AGE2, S_AGE2_CHK, S_SCAN, S_SCAN_CHK,
        S_EMIT, S_WAIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic age_rd;     // read tail entry time with given base
        logic age_use_now;
        logic age_drop;   // pop tail
        logic set_prev;
        logic idx_clr;
        logic idx_inc;
        logic reg_commit;
        logic move_commit;
        logic rd_scan;    // read entry at order[idx]
        logic emit;
        logic [2:0] emit_status;
        logic emit_entry; // take dest from read entry
        logic emit_last;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic tail_stale;
        logic count_zero;
        logic is_tick;
        logic bad_hdr;
        logic is_reg;
        logic reg_ok;
        logic free_hit;
        logic idx_end;   // idx reached count (or CLIENTS)
        logic addr_hit;  // read entry equals from_addr, and from_addr equals src_node
        logic dst_hit;   // read entry equals dst_node
        logic bcast;
        logic out_busy;
    } stat_t;
endpackage

// ----- rtl/trct_ctrl.sv -----
// Controller state machine of the tunnel relay client table
`timescale 1ns / 1ps
module trct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  trct_pkg::stat_t  st,
    output trct_pkg::cmd_t   cmd
);
    trct_pkg::state_t state_reg, state_next;
    logic found_reg, found_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trct_pkg::S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    // advance sequence
    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            trct_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = trct_pkg::S_AGE1;
                end
            end
            trct_pkg::S_AGE1:
            begin
                if (st.count_zero)
                begin
                    cmd.set_prev = 1'b1;
                    state_next = trct_pkg::S_CLASSIFY;
                end
                else
                begin
                    cmd.age_rd = 1'b1;
                    state_next = trct_pkg::S_AGE1_CHK;
                end
            end
            trct_pkg::S_AGE1_CHK:
            begin
                if (st.tail_stale)
                begin
                    cmd.age_drop = 1'b1;
                    state_next = trct_pkg::S_AGE1;
                end
                else
                begin
                    cmd.set_prev = 1'b1;
                    state_next = trct_pkg::S_CLASSIFY;
                end
            end
            trct_pkg::S_CLASSIFY:
            begin
                cmd.idx_clr = 1'b1;
                if (!st.out_busy)
                begin
                    cmd.emit_last = 1'b1;
                    if (st.is_tick)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_status = trct_pkg::ST_TICK;
                        state_next = trct_pkg::S_IDLE;
                    end
                    else if (st.bad_hdr)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_status = trct_pkg::ST_BAD;
                        state_next = trct_pkg::S_IDLE;
                    end
                    else if (st.is_reg)
                    begin
                        if (st.reg_ok)
                            state_next = trct_pkg::S_FREE;
                        else
                        begin
                            cmd.emit = 1'b1;
                            cmd.emit_status = trct_pkg::ST_REFUSED;
                            state_next = trct_pkg::S_IDLE;
                        end
                    end
                    else
                        state_next = trct_pkg::S_FIND;
                end
            end
            trct_pkg::S_FREE:
            begin
                // free slot search: idx walks slots
                if (st.free_hit)
                    state_next = trct_pkg::S_REG;
                else
                    cmd.idx_inc = 1'b1;
            end
            trct_pkg::S_REG:
            begin
                cmd.reg_commit = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_status = trct_pkg::ST_ACK;
                cmd.emit_last = 1'b1;
                state_next = trct_pkg::S_IDLE;
            end
            trct_pkg::S_FIND:
            begin
                if (st.idx_end)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = trct_pkg::ST_UNKNOWN;
                    cmd.emit_last = 1'b1;
                    state_next = trct_pkg::S_IDLE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next = trct_pkg::S_FIND_CHK;
                end
            end
            trct_pkg::S_FIND_CHK:
            begin
                if (st.addr_hit)
                    state_next = trct_pkg::S_MOVE;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = trct_pkg::S_FIND;
                end
            end
            trct_pkg::S_MOVE:
            begin
                cmd.move_commit = 1'b1;
                state_next = trct_pkg::S_AGE2;
            end
            trct_pkg::S_AGE2:
            begin
                if (st.count_zero)
                    state_next = trct_pkg::S_SCAN;
                else
                begin
                    cmd.age_rd = 1'b1;
                    cmd.age_use_now = 1'b1;
                    state_next = trct_pkg::S_AGE2_CHK;
                end
            end
            trct_pkg::S_AGE2_CHK:
            begin
                if (st.tail_stale)
                begin
                    cmd.age_drop = 1'b1;
                    state_next = trct_pkg::S_AGE2;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.idx_inc = 1'b1;
                    found_next = 1'b0;
                    state_next = trct_pkg::S_SCAN;
                end
            end
            trct_pkg::S_SCAN:
            begin
                if (st.idx_end)
                begin
                    if (!st.out_busy)
                    begin
                        if (!found_reg)
                        begin
                            cmd.emit = 1'b1;
                            cmd.emit_status = trct_pkg::ST_NOTARGET;
                            cmd.emit_last = 1'b1;
                            state_next = trct_pkg::S_IDLE;
                        end
                        else
                            state_next = trct_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next = trct_pkg::S_SCAN_CHK;
                end
            end
            trct_pkg::S_SCAN_CHK:
            begin
                if (st.bcast || st.dst_hit)
                    state_next = trct_pkg::S_EMIT;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = trct_pkg::S_SCAN;
                end
            end
            trct_pkg::S_EMIT:
            begin
                // one send per target, last on unicast or final broadcast
                if (!st.out_busy)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = trct_pkg::ST_FWD;
                    cmd.emit_entry = 1'b1;
                    found_next = 1'b1;
                    if (!st.bcast)
                    begin
                        cmd.emit_last = 1'b1;
                        state_next = trct_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next = trct_pkg::S_WAIT;
                    end
                end
            end
            trct_pkg::S_WAIT:
            begin
                // decide whether the held send was the final one
                if (st.idx_end)
                    state_next = trct_pkg::S_IDLE;
                else
                    state_next = trct_pkg::S_SCAN;
                cmd.emit_last = st.idx_end;
            end
            default:
                state_next = trct_pkg::S_IDLE;
        endcase
    end
endmodule

// ----- rtl/trct_dp.sv -----
// Datapath of the tunnel relay client table: table, order list, output register
`timescale 1ns / 1ps
module trct_dp #(
    parameter int CLIENTS = trct_pkg::CLIENTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  trct_pkg::cmd_t   cmd,
    output trct_pkg::stat_t  st,
    input  logic [31:0]      cfg_data,
    input  logic             cfg_we,
    input  logic [31:0]      now,
    input  logic [15:0]      rx_length,
    input  logic [15:0]      checksum,
    input  logic [15:0]      hdr_length,
    input  logic [7:0]       transcontrol,
    input  logic [31:0]      dst_net,
    input  logic [47:0]      dst_node,
    input  logic [15:0]      dest_socket,
    input  logic [31:0]      src_net,
    input  logic [47:0]      src_node,
    input  logic [15:0]      source_socket,
    input  logic [47:0]      from_addr,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       status,
    output logic [47:0]      dest_addr,
    output logic [15:0]      reply_dst_sock,
    output logic [15:0]      reply_src_sock,
    output logic [15:0]      send_length,
    output logic             last
);
    localparam int IW = $clog2(CLIENTS);
    localparam int CW = $clog2(CLIENTS + 1);
    localparam logic [CW-1:0] FULL = CW'(CLIENTS);

    logic [47:0] addr_mem [CLIENTS];
    logic [31:0] seen_mem [CLIENTS];
    logic [IW-1:0] order_reg [CLIENTS];
    logic [CLIENTS-1:0] valid_reg;
    logic [CW-1:0] count_reg;
    logic [31:0] prev_reg, age_reg;
    logic [CW-1:0] idx_reg;
    logic [47:0] rd_addr_reg;
    logic [31:0] rd_seen_reg, age_base_reg;
    logic [IW-1:0] rd_slot_reg;

    // captured item
    logic [31:0] now_reg;
    logic [15:0] rxl_reg, csum_reg, hlen_reg, dsock_reg, ssock_reg;
    logic [7:0] tc_reg;
    logic [31:0] dnet_reg, snet_reg;
    logic [47:0] dnode_reg, snode_reg, from_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        hold_reg, hold_next;
    logic [2:0]  status_reg, status_next;
    logic [47:0] dest_reg, dest_next;
    logic [15:0] rdsock_reg, rdsock_next;
    logic [15:0] rssock_reg, rssock_next;
    logic [15:0] len_reg, len_next;
    logic        last_reg, last_next;

    logic [IW-1:0] idx_i, tail_i;
    logic [31:0] age_diff;

    assign idx_i = idx_reg[IW-1:0];
    assign tail_i = IW'(count_reg - CW'(1));
    assign age_diff = age_base_reg - rd_seen_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now; rxl_reg <= rx_length; csum_reg <= checksum;
            hlen_reg <= hdr_length; tc_reg <= transcontrol; dnet_reg <= dst_net;
            dnode_reg <= dst_node; dsock_reg <= dest_socket; snet_reg <= src_net;
            snode_reg <= src_node; ssock_reg <= source_socket; from_reg <= from_addr;
        end
    end

    // entry memories: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.age_rd)
        begin
            rd_seen_reg <= seen_mem[order_reg[tail_i]];
            age_base_reg <= cmd.age_use_now ? now_reg : prev_reg;
        end
        if (cmd.rd_scan)
        begin
            rd_addr_reg <= addr_mem[order_reg[idx_i]];
            rd_slot_reg <= order_reg[idx_i];
        end
        if (cmd.reg_commit)
        begin
            addr_mem[idx_i] <= from_reg;
            seen_mem[idx_i] <= now_reg;
        end
        else if (cmd.move_commit)
            seen_mem[rd_slot_reg] <= now_reg;
    end

    // order list, valid bits, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            prev_reg <= '0;
            age_reg <= trct_pkg::AGE_RESET;
            idx_reg <= '0;
            for (int i = 0; i < CLIENTS; i++)
                order_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                age_reg <= cfg_data;
            if (cmd.set_prev)
                prev_reg <= now_reg;
            if (cmd.age_drop)
            begin
                valid_reg[order_reg[tail_i]] <= 1'b0;
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.idx_clr)
                idx_reg <= cmd.idx_inc ? CW'(1) : '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.reg_commit)
            begin
                valid_reg[idx_i] <= 1'b1;
                count_reg <= count_reg + CW'(1);
                order_reg[0] <= idx_i;
                for (int i = 1; i < CLIENTS; i++)
                    order_reg[i] <= order_reg[i-1];
            end
            if (cmd.move_commit)
            begin
                order_reg[0] <= rd_slot_reg;
                for (int i = 1; i < CLIENTS; i++)
                    if (CW'(i) <= idx_reg)
                        order_reg[i] <= order_reg[i-1];
            end
        end
    end

    // status to controller
    always_comb
    begin
        st = '0;
        st.tail_stale = age_diff > age_reg;
        st.count_zero = count_reg == '0;
        st.is_tick = rxl_reg == '0;
        st.bad_hdr = rxl_reg < trct_pkg::HDR_BYTES || csum_reg != trct_pkg::CSUM_OK ||
                     hlen_reg < trct_pkg::HDR_BYTES || hlen_reg > rxl_reg ||
                     (dnet_reg | snet_reg) != '0 || tc_reg != '0;
        st.is_reg = dnode_reg == '0;
        st.reg_ok = snode_reg == '0 && hlen_reg == trct_pkg::HDR_BYTES &&
                    count_reg < FULL;
        st.free_hit = !valid_reg[idx_i];
        st.idx_end = idx_reg >= count_reg;
        st.addr_hit = rd_addr_reg == from_reg && from_reg == snode_reg;
        st.dst_hit = rd_addr_reg == dnode_reg;
        st.bcast = dnode_reg == trct_pkg::NODE_BCAST;
        st.out_busy = out_valid_reg && !out_ready;
    end

    // next output item; a broadcast send is held until its last flag is known
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        hold_next = hold_reg;
        status_next = status_reg;
        dest_next = dest_reg;
        rdsock_next = rdsock_reg;
        rssock_next = rssock_reg;
        len_next = len_reg;
        last_next = last_reg;
        if (cmd.emit)
        begin
            status_next = cmd.emit_status;
            dest_next = '0;
            rdsock_next = '0;
            rssock_next = '0;
            len_next = '0;
            last_next = cmd.emit_last;
            if (cmd.emit_status == trct_pkg::ST_ACK)
            begin
                dest_next = from_reg;
                rdsock_next = ssock_reg;
                rssock_next = dsock_reg;
                len_next = trct_pkg::HDR_BYTES;
            end
            else if (cmd.emit_entry)
            begin
                dest_next = rd_addr_reg;
                len_next = hlen_reg;
            end
            if (cmd.emit_entry && st.bcast)
                hold_next = 1'b1;
            else
                out_valid_next = 1'b1;
        end
        else if (hold_reg)
        begin
            last_next = cmd.emit_last;
            out_valid_next = 1'b1;
            hold_next = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hold_reg <= 1'b0;
            status_reg <= '0;
            dest_reg <= '0;
            rdsock_reg <= '0;
            rssock_reg <= '0;
            len_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hold_reg <= hold_next;
            status_reg <= status_next;
            dest_reg <= dest_next;
            rdsock_reg <= rdsock_next;
            rssock_reg <= rssock_next;
            len_reg <= len_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign dest_addr = dest_reg;
    assign reply_dst_sock = rdsock_reg;
    assign reply_src_sock = rssock_reg;
    assign send_length = len_reg;
    assign last = last_reg;
endmodule

// ----- rtl/tunnel_relay_client_table_unit.sv -----
// Top level of the tunnel relay client table unit
`timescale 1ns / 1ps
// Relay client table: one packet header (or timeout tick) per input item,
// one or more result items out. Items are handled one at a time. Each item
// first drops aged-out entries; a registration then searches the low slots
// for a free one; a relayed packet searches the table for the sender,
// moves it to the head, and scans the entries for targets, with one send
// per target. Entries are read one at a time through the single read port
// of the entry table, and any stall on the result side holds the unit.
module tunnel_relay_client_table_unit #(
    parameter int CLIENTS = trct_pkg::CLIENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now,
    input  logic [15:0] rx_length,
    input  logic [15:0] checksum,
    input  logic [15:0] hdr_length,
    input  logic [7:0]  transcontrol,
    input  logic [31:0] dst_net,
    input  logic [47:0] dst_node,
    input  logic [15:0] dest_socket,
    input  logic [31:0] src_net,
    input  logic [47:0] src_node,
    input  logic [15:0] source_socket,
    input  logic [47:0] from_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [47:0] dest_addr,
    output logic [15:0] reply_dst_sock,
    output logic [15:0] reply_src_sock,
    output logic [15:0] send_length,
    output logic        last
);
    trct_pkg::cmd_t cmd;
    trct_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    trct_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .st(st), .cmd(cmd)
    );

    trct_dp #(.CLIENTS(CLIENTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .cfg_data(cfg_data), .cfg_we(cfg_valid),
        .now(now), .rx_length(rx_length), .checksum(checksum),
        .hdr_length(hdr_length), .transcontrol(transcontrol),
        .dst_net(dst_net), .dst_node(dst_node), .dest_socket(dest_socket),
        .src_net(src_net), .src_node(src_node), .source_socket(source_socket),
        .from_addr(from_addr), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .dest_addr(dest_addr), .reply_dst_sock(reply_dst_sock),
        .reply_src_sock(reply_src_sock), .send_length(send_length), .last(last)
    );
endmodule

// ----- rtl/trct_checker.sv -----
// Port checker for the tunnel relay client table unit
`timescale 1ns / 1ps
`include "tunnel_relay_client_table_unit_assert.svh"
module trct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] send_length,
    input logic        last
);
    `TRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "result dropped while stalled")
    `TRC_ASSERT_IMP(a_ack_len, clk, rst_n, out_valid && status == trct_pkg::ST_ACK, send_length == trct_pkg::HDR_BYTES && last, "bad ack")
    `TRC_ASSERT_IMP(a_single, clk, rst_n, out_valid && (status == trct_pkg::ST_BAD || status == trct_pkg::ST_TICK || status == trct_pkg::ST_UNKNOWN), last, "single result lacks last")
    `TRC_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "item taken while busy")
endmodule

bind tunnel_relay_client_table_unit trct_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .send_length(send_length), .last(last)
);

// ----- tb/tunnel_relay_client_table_unit_test.sv -----
// Self-checking testbench for the tunnel relay client table unit
`timescale 1ns / 1ps
module tunnel_relay_client_table_unit_test;
    localparam int NCLI = trct_pkg::CLIENTS_DEF;
    localparam logic [47:0] NODE_NULL = 48'h0;

    typedef struct packed {
        logic [2:0]  st;
        logic [47:0] addr;
        logic [15:0] dsock;
        logic [15:0] ssock;
        logic [15:0] len;
        logic        lst;
    } relay_res_t;

    typedef struct {
        logic [31:0] now;
        logic [15:0] rxl;
        logic [15:0] csum;
        logic [15:0] hlen;
        logic [7:0]  tc;
        logic [31:0] dnet;
        logic [47:0] dnode;
        logic [15:0] dsock;
        logic [31:0] snet;
        logic [47:0] snode;
        logic [15:0] ssock;
        logic [47:0] from;
    } packet_t;

    // Scoreboard: own copy of the client table and the queue of pending sends
    class relay_scoreboard;
        bit          live[NCLI];
        logic [47:0] addr[NCLI];
        logic [31:0] seen[NCLI];
        int          order[NCLI];
        int          count;
        logic [31:0] prev_time;
        logic [31:0] age_limit;
        relay_res_t  pending[$];
        int          mismatches;

        function void clear();
            foreach (live[i]) live[i] = 0;
            count = 0;
            prev_time = 0;
            age_limit = trct_pkg::AGE_RESET;
            pending.delete();
            mismatches = 0;
        endfunction

        function void drop_stale(logic [31:0] t);
            int s;
            while (count > 0) begin
                s = order[count-1];
                if (32'(t - seen[s]) > age_limit) begin
                    live[s] = 0;
                    count--;
                end else break;
            end
        endfunction

        function void push(logic [2:0] st, logic [47:0] a, logic [15:0] ds,
                           logic [15:0] ss, logic [15:0] len);
            relay_res_t r;
            r.st = st; r.addr = a; r.dsock = ds; r.ssock = ss; r.len = len;
            r.lst = 1'b1;
            pending.push_back(r);
        endfunction

        // Note an accepted packet: update the table and queue its sends
        function void note_packet(packet_t p);
            int slot, pos, s, k;
            relay_res_t r;
            drop_stale(prev_time);
            prev_time = p.now;
            if (p.rxl == 0) begin
                push(trct_pkg::ST_TICK, 0, 0, 0, 0);
                return;
            end
            if (p.rxl < trct_pkg::HDR_BYTES || p.csum != trct_pkg::CSUM_OK ||
                p.hlen < trct_pkg::HDR_BYTES || p.hlen > p.rxl || p.dnet != 0 ||
                p.snet != 0 || p.tc != 0) begin
                push(trct_pkg::ST_BAD, 0, 0, 0, 0);
                return;
            end
            if (p.dnode == NODE_NULL) begin
                slot = NCLI;
                if (p.snode == 0 && p.hlen == trct_pkg::HDR_BYTES && count < NCLI)
                    for (int i = 0; i < NCLI; i++)
                        if (!live[i]) begin slot = i; break; end
                if (slot >= NCLI) begin
                    push(trct_pkg::ST_REFUSED, 0, 0, 0, 0);
                    return;
                end
                live[slot] = 1; addr[slot] = p.from; seen[slot] = p.now;
                for (int i = count; i > 0; i--) order[i] = order[i-1];
                order[0] = slot;
                count++;
                push(trct_pkg::ST_ACK, p.from, p.ssock, p.dsock, trct_pkg::HDR_BYTES);
                return;
            end
            pos = NCLI;
            if (p.from == p.snode)
                for (int i = 0; i < count; i++)
                    if (addr[order[i]] == p.from) begin pos = i; break; end
            if (pos >= NCLI) begin
                push(trct_pkg::ST_UNKNOWN, 0, 0, 0, 0);
                return;
            end
            s = order[pos];
            for (int i = pos; i > 0; i--) order[i] = order[i-1];
            order[0] = s;
            seen[s] = p.now;
            drop_stale(p.now);
            k = 0;
            for (int i = 1; i < count; i++) begin
                if (p.dnode == trct_pkg::NODE_BCAST || addr[order[i]] == p.dnode) begin
                    r.st = trct_pkg::ST_FWD; r.addr = addr[order[i]]; r.dsock = 0;
                    r.ssock = 0; r.len = p.hlen; r.lst = 1'b0;
                    pending.push_back(r);
                    k++;
                    if (p.dnode != trct_pkg::NODE_BCAST) break;
                end
            end
            if (k == 0) push(trct_pkg::ST_NOTARGET, 0, 0, 0, 0);
            else pending[$].lst = 1'b1;
        endfunction

        // Check one result against the oldest pending send
        function void check_result(relay_res_t got);
            relay_res_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", exp, got);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        cfg_valid, cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid, in_ready;
    logic [31:0] now;
    logic [15:0] rx_length, checksum, hdr_length;
    logic [7:0]  transcontrol;
    logic [31:0] dst_net, src_net;
    logic [47:0] dst_node, src_node, from_addr;
    logic [15:0] dest_socket, source_socket;
    logic        out_valid, out_ready;
    logic [2:0]  status;
    logic [47:0] dest_addr;
    logic [15:0] reply_dst_sock, reply_src_sock, send_length;
    logic        last;

    relay_scoreboard board;
    logic [31:0] clock_secs;
    logic [47:0] known[$];
    bit          calm;
    bit          stall_req;
    bit          stall_on;

    tunnel_relay_client_table_unit DUT (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Hold the result side off for a long stretch once asked
    initial
    begin
        wait (stall_req);
        stall_on <= 1'b1;
        repeat (300) @(posedge clk);
        stall_on <= 1'b0;
    end

    // Collect results, stalling at random or through the long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{status, dest_addr, reply_dst_sock,
                                 reply_src_sock, send_length, last});
        out_ready <= !stall_on && (calm || ($urandom_range(99) >= 11));
    end

    task automatic write_age(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.age_limit = v;
    endtask

    task automatic send_packet(packet_t p);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now <= p.now; rx_length <= p.rxl; checksum <= p.csum;
        hdr_length <= p.hlen; transcontrol <= p.tc; dst_net <= p.dnet;
        dst_node <= p.dnode; dest_socket <= p.dsock; src_net <= p.snet;
        src_node <= p.snode; source_socket <= p.ssock; from_addr <= p.from;
        do @(posedge clk); while (!in_ready);
        board.note_packet(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic packet_t good_hdr(logic [31:0] t);
        packet_t p;
        p.now = t; p.rxl = 16'(30 + $urandom_range(40)); p.csum = trct_pkg::CSUM_OK;
        p.hlen = trct_pkg::HDR_BYTES; p.tc = 0; p.dnet = 0; p.snet = 0;
        p.dnode = 0; p.snode = 0;
        p.dsock = 16'($urandom); p.ssock = 16'($urandom);
        p.from = {$urandom, 16'($urandom)};
        return p;
    endfunction

    function automatic packet_t reg_pkt(logic [31:0] t);
        packet_t p;
        p = good_hdr(t);
        if (known.size() > 0 && $urandom_range(9) == 0)
            p.from = known[$urandom_range(known.size() - 1)];
        known.push_back(p.from);
        return p;
    endfunction

    function automatic packet_t relay_pkt(logic [31:0] t);
        packet_t p;
        p = good_hdr(t);
        p.hlen = 16'(30 + $urandom_range(p.rxl - 30));
        if (known.size() > 0)
            p.from = known[$urandom_range(known.size() - 1)];
        p.snode = p.from;
        case ($urandom_range(3))
            0, 1: p.dnode = trct_pkg::NODE_BCAST;
            2: p.dnode = known.size() ? known[$urandom_range(known.size()-1)]
                                      : 48'h1;
            default: p.dnode = {$urandom, 16'($urandom)};
        endcase
        return p;
    endfunction

    // Damage one header field, or pick a corner, for noise items
    function automatic packet_t noisy_pkt(logic [31:0] t);
        packet_t p;
        p = relay_pkt(t);
        case ($urandom_range(9))
            0: p.rxl = 0;
            1: p.rxl = 16'($urandom_range(29));
            2: p.csum = 16'($urandom);
            3: p.hlen = 16'($urandom);
            4: p.tc = 8'($urandom_range(1, 255));
            5: p.dnet = $urandom;
            6: p.snet = $urandom;
            7: p.snode = {$urandom, 16'($urandom)};
            8: begin p.dnode = 0; p.snode = 48'($urandom_range(1, 3)); end
            default: begin p.dnode = 0; p.hlen = 31; p.rxl = 40; end
        endcase
        return p;
    endfunction

    initial
    begin
        packet_t p;
        board = new();
        board.clear();
        rst_n = 0; calm = 0; stall_req = 0;
        cfg_valid = 0; cfg_data = 0; in_valid = 0; out_ready = 0;
        now = 0; rx_length = 0; checksum = 0; hdr_length = 0; transcontrol = 0;
        dst_net = 0; dst_node = 0; dest_socket = 0; src_net = 0; src_node = 0;
        source_socket = 0; from_addr = 0;
        clock_secs = 100;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick, each bad header, registration, relay, extremes
        p = good_hdr(clock_secs); p.rxl = 0; send_packet(p);
        p = good_hdr(clock_secs); p.rxl = 29; send_packet(p);
        p = good_hdr(clock_secs); p.csum = 16'hfffe; send_packet(p);
        p = good_hdr(clock_secs); p.hlen = 29; send_packet(p);
        p = good_hdr(clock_secs); p.rxl = 30; p.hlen = 31; send_packet(p);
        p = good_hdr(clock_secs); p.dnet = 32'hffffffff; send_packet(p);
        p = good_hdr(clock_secs); p.snet = 32'h1; send_packet(p);
        p = good_hdr(clock_secs); p.tc = 8'hff; send_packet(p);
        p = good_hdr(clock_secs); p.snode = 48'hffffffffffff; send_packet(p);
        p = good_hdr(clock_secs); p.hlen = 31; send_packet(p);
        p = relay_pkt(clock_secs); send_packet(p);
        p = good_hdr(clock_secs); p.from = 48'hffffffffffff;
        p.ssock = 16'hffff; p.dsock = 16'hffff; known.push_back(p.from);
        send_packet(p);
        p = good_hdr(clock_secs); p.from = 48'h000000000001; p.ssock = 0;
        p.dsock = 0; known.push_back(p.from); send_packet(p);
        p = good_hdr(clock_secs); p.from = 48'h000000000001;
        send_packet(p);
        p = relay_pkt(clock_secs); p.from = 48'h1; p.snode = 48'h1;
        p.dnode = trct_pkg::NODE_BCAST; p.rxl = 16'hffff; p.hlen = 16'hffff;
        send_packet(p);
        p = relay_pkt(clock_secs); p.from = 48'h1; p.snode = 48'h1;
        p.dnode = 48'hffffffffffff - 1; send_packet(p);
        p = relay_pkt(clock_secs); p.from = 48'hffffffffffff;
        p.snode = p.from; p.dnode = 48'h1; send_packet(p);
        drain();

        // Fill the table to refusal with no idling, then age everyone out
        calm = 1;
        write_age(32'hffffffff);
        for (int i = 0; i < 34; i++) send_packet(reg_pkt(clock_secs + i));
        stall_req = 1;
        for (int i = 0; i < 4; i++) send_packet(relay_pkt(clock_secs + 40));
        drain();
        calm = 0;
        write_age(0);
        clock_secs = clock_secs + 5;
        p = good_hdr(clock_secs); p.rxl = 0; send_packet(p);
        p = good_hdr(clock_secs); p.rxl = 0; send_packet(p);
        known.delete();
        drain();

        // Random phases under several age limits
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_age(trct_pkg::AGE_RESET);
                1: write_age(3);
                2: write_age($urandom);
                default: write_age(20);
            endcase
            for (int i = 0; i < 20; i++)
            begin
                clock_secs = clock_secs + $urandom_range(4);
                if ($urandom_range(99) < 3) clock_secs = $urandom;
                case ($urandom_range(9))
                    0, 1, 2: p = reg_pkt(clock_secs);
                    3, 4, 5, 6, 7: p = relay_pkt(clock_secs);
                    default: p = noisy_pkt(clock_secs);
                endcase
                send_packet(p);
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/trct_pkg.sv
rtl/trct_ctrl.sv
rtl/trct_dp.sv
rtl/tunnel_relay_client_table_unit.sv
rtl/trct_checker.sv
tb/tunnel_relay_client_table_unit_test.sv
